[sv/assert_macros.svh]
// Assertion macros shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SAC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define SAC_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define SAC_ASSERT(lbl, prop)
`define SAC_NEVER(lbl, expr)
`endif
`endif

[sv/sac_pkg.sv]
// Types, codes and constants of the source authority checker.
package sac_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam logic [2:0] NO_HEALTH = 3'd7;

    typedef enum logic [1:0] {
        FUNC_REG  = 2'd0,
        FUNC_VAL  = 2'd1,
        FUNC_RST  = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        DEC_OK       = 4'd0,
        DEC_UNREG    = 4'd1,
        DEC_EPOCH    = 4'd2,
        DEC_SRCGEN   = 4'd3,
        DEC_OBSGEN   = 4'd4,
        DEC_BOOT     = 4'd5,
        DEC_ORDER    = 4'd6,
        DEC_DUP      = 4'd7,
        DEC_FULL     = 4'd8
    } decision_t;

    typedef enum logic [0:0] {
        CFG_HEALTHY    = 1'b0,
        CFG_RESTARTING = 1'b1
    } cfg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [63:0] source_id;
        logic [63:0] worker_id;
        logic [63:0] epoch;
        logic [63:0] src_gen;
        logic [63:0] obs_gen;
        logic [63:0] boot_id;
        logic [63:0] seq;
        logic        ts_present;
        logic [63:0] obs_ts;
        logic [2:0]  health_in;
        logic        force_reassign;
    } in_item_t;

    typedef struct packed {
        decision_t   decision;
        logic [63:0] entry_epoch;
        logic [63:0] entry_src_gen;
        logic [63:0] entry_obs_gen;
        logic [63:0] entry_last_seq;
        logic [2:0]  entry_health;
        logic [31:0] entry_restarts;
    } out_item_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [63:0] epoch;
        logic [63:0] src_gen;
        logic [63:0] obs_gen;
        logic [63:0] boot;
        logic [63:0] prev_seq;
        logic [2:0]  health;
        logic [31:0] restarts;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic hit;
        logic full;
    } cam_status_t;

endpackage

[sv/source_authority_checker_core.sv]
// Top level of the source authority checker: sequencer, update logic and result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid / in_ready   | in_data  (in_item_t)
//  out     | output    | out_valid / out_ready | out_data (out_item_t)
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// Each item passes an accept step and an update step: in the accept cycle
// the key is matched against the key store and the entry memory read is issued;
// in the update step the returned entry is checked and updated, written back
// and the result is loaded into the output register. The entry memory has a
// registered read. The result register frees the input side: a new item is
// taken while a result still waits, and the update step only holds while the
// output register is full and not being taken. Reset empties the table at
// once through the valid bits and restores both health codes.
`include "assert_macros.svh"
module source_authority_checker_core import sac_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [2:0] cfg_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    state_t      state_reg, state_next;
    in_item_t    item_reg;
    logic [IW-1:0] idx_reg;
    cam_status_t st_reg;
    logic [2:0]  healthy_reg, restarting_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic [IW-1:0] cam_idx;
    cam_status_t   cam_st;
    entry_t        old_e, new_e;
    logic          accept, slot_free, finish;
    logic          wr_en;
    decision_t     dec;
    logic          health_given;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign finish    = (state_reg == ST_EXEC) && slot_free;

    sac_cam #(.ENTRIES(ENTRIES)) u_cam (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_src (in_data.source_id),
        .key_wrk (in_data.worker_id),
        .idx     (cam_idx),
        .status  (cam_st),
        .wr_en   (wr_en),
        .wr_idx  (idx_reg),
        .wr_src  (item_reg.source_id),
        .wr_wrk  (item_reg.worker_id)
    );

    sac_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (new_e),
        .rd_en   (accept),
        .rd_addr (cam_idx),
        .rd_data (old_e)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    // Entry update and decision.
    always_comb
    begin
        health_given = item_reg.health_in != NO_HEALTH;
        new_e        = old_e;
        dec          = DEC_OK;
        wr_en        = 1'b0;
        case (item_reg.func)
            FUNC_REG:
            begin
                if (!st_reg.hit && st_reg.full)
                begin
                    dec = DEC_FULL;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (st_reg.hit && !item_reg.force_reassign
                        && old_e.boot == item_reg.boot_id
                        && old_e.src_gen == item_reg.src_gen
                        && old_e.obs_gen == item_reg.obs_gen)
                    begin
                        new_e.epoch = item_reg.epoch;
                        if (health_given)
                        begin
                            new_e.health = item_reg.health_in;
                        end
                    end
                    else
                    begin
                        new_e.epoch    = item_reg.epoch;
                        new_e.src_gen  = item_reg.src_gen;
                        new_e.obs_gen  = item_reg.obs_gen;
                        new_e.boot     = item_reg.boot_id;
                        new_e.prev_seq = '0;
                        new_e.health   = health_given ? item_reg.health_in : healthy_reg;
                        if (!st_reg.hit)
                        begin
                            new_e.restarts = '0;
                        end
                        else if (old_e.restarts != '1)
                        begin
                            new_e.restarts = old_e.restarts + 32'd1;
                        end
                    end
                end
            end
            FUNC_VAL:
            begin
                if (!st_reg.hit)
                    dec = DEC_UNREG;
                else if (item_reg.epoch < old_e.epoch)
                    dec = DEC_EPOCH;
                else if (item_reg.src_gen != old_e.src_gen)
                    dec = DEC_SRCGEN;
                else if (item_reg.obs_gen != old_e.obs_gen)
                    dec = DEC_OBSGEN;
                else if (item_reg.boot_id != old_e.boot)
                    dec = DEC_BOOT;
                else if (item_reg.seq < old_e.prev_seq)
                    dec = DEC_ORDER;
                else if (item_reg.seq == old_e.prev_seq && old_e.prev_seq != '0)
                    dec = DEC_DUP;
                if (dec == DEC_OK)
                begin
                    wr_en          = 1'b1;
                    new_e.prev_seq = item_reg.seq;
                    if (health_given)
                    begin
                        new_e.health = item_reg.health_in;
                    end
                end
            end
            FUNC_RST:
            begin
                if (!st_reg.hit && st_reg.full)
                begin
                    dec = DEC_FULL;
                end
                else
                begin
                    wr_en          = 1'b1;
                    new_e.epoch    = item_reg.epoch;
                    new_e.boot     = item_reg.boot_id;
                    new_e.prev_seq = '0;
                    new_e.health   = restarting_reg;
                    if (st_reg.hit)
                    begin
                        if (old_e.src_gen != '1) new_e.src_gen = old_e.src_gen + 64'd1;
                        if (old_e.obs_gen != '1) new_e.obs_gen = old_e.obs_gen + 64'd1;
                        if (old_e.restarts != '1) new_e.restarts = old_e.restarts + 32'd1;
                    end
                    else
                    begin
                        new_e.src_gen  = 64'd1;
                        new_e.obs_gen  = 64'd1;
                        new_e.restarts = '0;
                    end
                end
            end
            default:
            begin
                dec = DEC_OK;
            end
        endcase
        wr_en = wr_en && finish;
    end

    // Result register load.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (finish && item_reg.func != FUNC_NONE)
        begin
            out_valid_next = 1'b1;
            out_data_next.decision = dec;
            if (dec == DEC_UNREG || dec == DEC_FULL)
            begin
                out_data_next.entry_epoch    = '0;
                out_data_next.entry_src_gen  = '0;
                out_data_next.entry_obs_gen  = '0;
                out_data_next.entry_last_seq = '0;
                out_data_next.entry_health   = '0;
                out_data_next.entry_restarts = '0;
            end
            else
            begin
                out_data_next.entry_epoch    = new_e.epoch;
                out_data_next.entry_src_gen  = new_e.src_gen;
                out_data_next.entry_obs_gen  = new_e.obs_gen;
                out_data_next.entry_last_seq = new_e.prev_seq;
                out_data_next.entry_health   = new_e.health;
                out_data_next.entry_restarts = new_e.restarts;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            healthy_reg    <= 3'd0;
            restarting_reg <= 3'd1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_HEALTHY:    healthy_reg    <= cfg_data;
                    CFG_RESTARTING: restarting_reg <= cfg_data;
                    default:        healthy_reg    <= healthy_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            item_reg <= in_data;
            idx_reg  <= cam_idx;
            st_reg   <= cam_st;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SAC_ASSERT(a_exec_leaves, (state_reg == ST_EXEC && slot_free) |=> state_reg == ST_IDLE)
    `SAC_NEVER(a_full_no_write, wr_en && !st_reg.hit && st_reg.full)
    `SAC_ASSERT(a_miss_zero, (out_valid_reg && out_data_reg.decision == DEC_UNREG) |-> (out_data_reg.entry_epoch == '0 && out_data_reg.entry_restarts == '0))

endmodule

[sv/sac_ram.sv]
// Generic single-port-write, registered-read RAM.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/sac_cam.sv]
// Key store with valid bits, full-key match and lowest-free-entry search.
`include "assert_macros.svh"
module sac_cam import sac_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [63:0]    key_src,
    input  logic [63:0]    key_wrk,
    output logic [IW-1:0]  idx,
    output cam_status_t    status,
    input  logic           wr_en,
    input  logic [IW-1:0]  wr_idx,
    input  logic [63:0]    wr_src,
    input  logic [63:0]    wr_wrk
);

    logic [ENTRIES-1:0] valid_reg;
    logic [63:0]        src_reg [ENTRIES];
    logic [63:0]        wrk_reg [ENTRIES];
    logic [ENTRIES-1:0] match;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      free_idx;
    logic               any_free;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        any_free = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (src_reg[i] == key_src) && (wrk_reg[i] == key_wrk);
            if (match[i])
            begin
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
                any_free = 1'b1;
            end
        end
        status.hit  = |match;
        status.full = !any_free;
        idx         = status.hit ? hit_idx : free_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            src_reg[wr_idx] <= wr_src;
            wrk_reg[wr_idx] <= wr_wrk;
        end
    end

    `SAC_ASSERT(a_match_unique, $onehot0(match))
    `SAC_ASSERT(a_full_means_no_free, status.full |-> (&valid_reg))
    `SAC_NEVER(a_valid_sticky, |($past(valid_reg) & ~valid_reg))

endmodule
